@@ hdl/jse_pkg.sv @@
// Shared types, character constants and helpers for the JSON string escaper.
`default_nettype none
package jse_pkg;

   // How the back end expands one string byte.
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_PLAIN,
      KIND_SHORT,
      KIND_UHEX
   } kind_type;

   // One classified request, passed from the front end to the back end.
   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic       open_q;
      logic       close_q;
      logic       valid;
   } entry_type;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + {4'd0, nib};
      end else begin
         c = CHAR_LOW_A + {4'd0, nib} - 8'd10;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

@@ hdl/jse_front.sv @@
// Front end: accepts requests, runs the UTF-8 checker and classifies each byte.
`default_nettype none
module jse_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_data_byte,
   input  wire logic              req_first_byte,
   input  wire logic              req_last_byte,
   input  wire logic              req_empty_string,
   input  wire logic              q_full,
   output logic                   q_push,
   output jse_pkg::entry_type     q_entry
);

   localparam logic [2:0] RULE_GEN = 3'd0;
   localparam logic [2:0] RULE_A0  = 3'd1;
   localparam logic [2:0] RULE_9F  = 3'd2;
   localparam logic [2:0] RULE_90  = 3'd3;
   localparam logic [2:0] RULE_8F  = 3'd4;

   logic [1:0] pend_ff, pend_in;
   logic [2:0] rule_ff, rule_in;
   logic       err_ff, err_in;

   logic [1:0] pend_s, pend_c;
   logic [2:0] rule_s, rule_c;
   logic       err_s, err_c;
   logic [7:0] b;

   function automatic logic cont_ok(input logic [7:0] v, input logic [2:0] rule);
      logic ok;
      unique case (rule)
         RULE_A0: ok = (v >= 8'ha0) && (v <= 8'hbf);
         RULE_9F: ok = (v >= 8'h80) && (v <= 8'h9f);
         RULE_90: ok = (v >= 8'h90) && (v <= 8'hbf);
         RULE_8F: ok = (v >= 8'h80) && (v <= 8'h8f);
         default: ok = (v >= 8'h80) && (v <= 8'hbf);
      endcase
      return ok;
   endfunction

   assign b         = req_data_byte;
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      // A first marker restarts the checker.
      pend_s = req_first_byte ? 2'd0 : pend_ff;
      rule_s = req_first_byte ? RULE_GEN : rule_ff;
      err_s  = req_first_byte ? 1'b0 : err_ff;

      pend_c = pend_s;
      rule_c = rule_s;
      err_c  = err_s;
      if (pend_s != 2'd0) begin
         if (cont_ok(b, rule_s)) begin
            pend_c = pend_s - 2'd1;
         end else begin
            err_c  = 1'b1;
            pend_c = 2'd0;
         end
         rule_c = RULE_GEN;
      end else if (b <= 8'h7f) begin
         pend_c = 2'd0;
      end else if (b >= 8'hc2 && b <= 8'hdf) begin
         pend_c = 2'd1;
         rule_c = RULE_GEN;
      end else if (b >= 8'he0 && b <= 8'hef) begin
         pend_c = 2'd2;
         rule_c = (b == 8'he0) ? RULE_A0 : (b == 8'hed) ? RULE_9F : RULE_GEN;
      end else if (b >= 8'hf0 && b <= 8'hf4) begin
         pend_c = 2'd3;
         rule_c = (b == 8'hf0) ? RULE_90 : (b == 8'hf4) ? RULE_8F : RULE_GEN;
      end else begin
         err_c = 1'b1;
      end

      q_entry.data    = b;
      q_entry.kind    = jse_pkg::KIND_PLAIN;
      q_entry.open_q  = req_first_byte;
      q_entry.close_q = req_last_byte;
      q_entry.valid   = !(err_c || (pend_c != 2'd0));

      unique case (b)
         8'h22: q_entry.kind = jse_pkg::KIND_SHORT;
         8'h5c: q_entry.kind = jse_pkg::KIND_SHORT;
         8'h08: begin q_entry.kind = jse_pkg::KIND_SHORT; q_entry.data = 8'h62; end
         8'h0c: begin q_entry.kind = jse_pkg::KIND_SHORT; q_entry.data = 8'h66; end
         8'h0a: begin q_entry.kind = jse_pkg::KIND_SHORT; q_entry.data = 8'h6e; end
         8'h0d: begin q_entry.kind = jse_pkg::KIND_SHORT; q_entry.data = 8'h72; end
         8'h09: begin q_entry.kind = jse_pkg::KIND_SHORT; q_entry.data = 8'h74; end
         default: begin
            if (b < 8'h20) q_entry.kind = jse_pkg::KIND_UHEX;
         end
      endcase

      pend_in = pend_c;
      rule_in = rule_c;
      err_in  = err_c;

      if (req_empty_string) begin
         q_entry.kind    = jse_pkg::KIND_NONE;
         q_entry.open_q  = 1'b1;
         q_entry.close_q = 1'b1;
         q_entry.valid   = 1'b1;
      end
      // Drop checker state once a string closes.
      if (req_empty_string || req_last_byte) begin
         pend_in = 2'd0;
         rule_in = RULE_GEN;
         err_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
         rule_ff <= RULE_GEN;
         err_ff  <= 1'b0;
      end else if (q_push) begin
         pend_ff <= pend_in;
         rule_ff <= rule_in;
         err_ff  <= err_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/jse_queue.sv @@
// Small FIFO of classified requests between the front and back ends.
`default_nettype none
module jse_queue #(
   parameter int DEPTH = jse_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire jse_pkg::entry_type push_entry,
   input  wire logic               pop,
   output jse_pkg::entry_type      head,
   output logic                    not_empty,
   output logic                    full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   jse_pkg::entry_type mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign head      = mem[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CW'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      if (push && !pop)      count_in = count_ff + CW'(1);
      else if (pop && !push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/jse_back.sv @@
// Back end: expands classified requests into chars, one per cycle unless stalled.
`default_nettype none
module jse_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire jse_pkg::entry_type head,
   input  wire logic               q_not_empty,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_out_char,
   output logic                    rsp_run_end,
   output logic                    rsp_string_end,
   output logic                    rsp_string_valid
);

   jse_pkg::entry_type cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [3:0] idx_ff, idx_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] char_ff, char_in;
   logic       run_end_ff, run_end_in;
   logic       str_end_ff, str_end_in;
   logic       str_ok_ff, str_ok_in;

   logic [2:0] body_len;
   logic [3:0] total, pos;
   logic [7:0] body_char;
   logic       fire, last;

   always_comb begin
      unique case (cur_ff.kind)
         jse_pkg::KIND_NONE:  body_len = 3'd0;
         jse_pkg::KIND_PLAIN: body_len = 3'd1;
         jse_pkg::KIND_SHORT: body_len = 3'd2;
         jse_pkg::KIND_UHEX:  body_len = 3'd6;
      endcase
      total = {3'd0, cur_ff.open_q} + {1'b0, body_len} + {3'd0, cur_ff.close_q};
      pos   = idx_ff - {3'd0, cur_ff.open_q};

      unique case (cur_ff.kind)
         jse_pkg::KIND_SHORT: body_char = (pos == 4'd0) ? jse_pkg::CHAR_BSLASH : cur_ff.data;
         jse_pkg::KIND_UHEX: begin
            unique case (pos[2:0])
               3'd0:    body_char = jse_pkg::CHAR_BSLASH;
               3'd1:    body_char = jse_pkg::CHAR_U;
               3'd2:    body_char = jse_pkg::CHAR_ZERO;
               3'd3:    body_char = jse_pkg::CHAR_ZERO;
               3'd4:    body_char = jse_pkg::hex_char(cur_ff.data[7:4]);
               default: body_char = jse_pkg::hex_char(cur_ff.data[3:0]);
            endcase
         end
         jse_pkg::KIND_PLAIN: body_char = cur_ff.data;
         jse_pkg::KIND_NONE:  body_char = cur_ff.data;
      endcase

      fire  = cur_valid_ff && (!rsp_valid_ff || rsp_ready);
      last  = (idx_ff == total - 4'd1);
      q_pop = q_not_empty && (!cur_valid_ff || (fire && last));

      char_in    = char_ff;
      run_end_in = run_end_ff;
      str_end_in = str_end_ff;
      str_ok_in  = str_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         run_end_in   = last;
         str_end_in   = 1'b0;
         str_ok_in    = 1'b0;
         if (cur_ff.open_q && idx_ff == 4'd0) begin
            char_in = jse_pkg::CHAR_QUOTE;
         end else if (pos < {1'b0, body_len}) begin
            char_in = body_char;
         end else begin
            char_in    = jse_pkg::CHAR_QUOTE;
            str_end_in = 1'b1;
            str_ok_in  = cur_ff.valid;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (q_pop) begin
         cur_in       = head;
         cur_valid_in = 1'b1;
         idx_in       = 4'd0;
      end else if (fire && last) begin
         cur_valid_in = 1'b0;
         idx_in       = 4'd0;
      end else if (fire) begin
         idx_in = idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      char_ff    <= char_in;
      run_end_ff <= run_end_in;
      str_end_ff <= str_end_in;
      str_ok_ff  <= str_ok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_char     = char_ff;
   assign rsp_run_end      = run_end_ff;
   assign rsp_string_end   = str_end_ff;
   assign rsp_string_valid = str_ok_ff;

endmodule
`default_nettype wire

@@ hdl/json_string_escape_utf8_check_top.sv @@
// Top level of the JSON string escaper with strict UTF-8 checking.
//
// Request channel (req_*): one string byte per request with first/last
// markers, or an empty-string marker. Response channel (rsp_*): one output
// character per response; rsp_run_end marks the last character of a
// request, rsp_string_end the closing quote, which carries rsp_string_valid.
// The front end checks UTF-8 and classifies the byte in the accept cycle and
// writes it into a QUEUE_DEPTH-entry queue; the back end reads it and emits
// one character per cycle through a registered output stage.
// When the pipeline is empty, the first character of a request passes the
// queue, the back end's current-request register and the output register.
// Throughput: one character per cycle unless the receiver stalls, set by the
// back end's single output register. A plain byte expands to 1 character, a
// short escape to 2, a \u00XX escape to 6, plus one per opening or closing
// quote; an empty string gives 2. While the receiver stalls, the output
// holds and the queue fills; req_ready drops once the queue is full.
// Reset clears the checker state, the queue and the output valid.
`default_nettype none
module json_string_escape_utf8_check_top #(
   parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_first_byte,
   input  wire logic       req_last_byte,
   input  wire logic       req_empty_string,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_run_end,
   output logic            rsp_string_end,
   output logic            rsp_string_valid
);

   jse_pkg::entry_type push_entry, head;
   logic q_push, q_pop, q_full, q_not_empty;

   jse_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_first_byte   (req_first_byte),
      .req_last_byte    (req_last_byte),
      .req_empty_string (req_empty_string),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (push_entry)
   );

   jse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .not_empty  (q_not_empty),
      .full       (q_full)
   );

   jse_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .q_not_empty      (q_not_empty),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_run_end      (rsp_run_end),
      .rsp_string_end   (rsp_string_end),
      .rsp_string_valid (rsp_string_valid)
   );

endmodule
`default_nettype wire

@@ bench/jse_stream_checker.sv @@
// Predictor and response checker for the JSON string escaper with UTF-8 checking.
`timescale 1ns / 100ps
module jse_stream_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_first_byte,
   input  wire logic       req_last_byte,
   input  wire logic       req_empty_string,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [7:0] rsp_out_char,
   input  wire logic       rsp_run_end,
   input  wire logic       rsp_string_end,
   input  wire logic       rsp_string_valid,
   output int              mismatch_count,
   output int              chars_pending,
   output int              chars_checked,
   output int              strings_good,
   output int              strings_bad
);

   typedef struct packed {
      logic [7:0] ch;
      logic       run_end;
      logic       str_end;
      logic       str_ok;
   } json_char_type;

   // Allowed range for the next continuation byte.
   typedef enum logic [2:0] {
      RULE_ANY,
      RULE_A0_BF,
      RULE_80_9F,
      RULE_90_BF,
      RULE_80_8F
   } cont_rule_type;

   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;
   localparam logic [7:0] CHAR_FORMFEED  = 8'h0c;
   localparam logic [7:0] CHAR_RETURN    = 8'h0d;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;

   string         hex_digits = "0123456789abcdef";
   logic [1:0]    cont_left;
   cont_rule_type cont_rule;
   logic          bad_seen;
   json_char_type expected_chars[$];
   json_char_type staged;
   logic          staged_ok;

   initial begin
      mismatch_count = 0;
      chars_pending  = 0;
      chars_checked  = 0;
      strings_good   = 0;
      strings_bad    = 0;
      staged_ok      = 1'b0;
   end

   task automatic clear_utf8();
      cont_left = 2'd0;
      cont_rule = RULE_ANY;
      bad_seen  = 1'b0;
   endtask

   function automatic logic cont_fits(input logic [7:0] b, input cont_rule_type r);
      logic ok;
      unique case (r)
         RULE_A0_BF: ok = (b >= 8'ha0) && (b <= 8'hbf);
         RULE_80_9F: ok = (b >= 8'h80) && (b <= 8'h9f);
         RULE_90_BF: ok = (b >= 8'h90) && (b <= 8'hbf);
         RULE_80_8F: ok = (b >= 8'h80) && (b <= 8'h8f);
         default:    ok = (b >= 8'h80) && (b <= 8'hbf);
      endcase
      return ok;
   endfunction

   task automatic advance_utf8(input logic [7:0] b);
      if (cont_left != 2'd0) begin
         if (cont_fits(b, cont_rule)) begin
            cont_left = cont_left - 2'd1;
         end else begin
            // drop the broken sequence, keep the error until the string ends
            bad_seen  = 1'b1;
            cont_left = 2'd0;
         end
         cont_rule = RULE_ANY;
      end else if (b[7]) begin
         if (b >= 8'hc2 && b <= 8'hdf) begin
            cont_left = 2'd1;
            cont_rule = RULE_ANY;
         end else if (b >= 8'he0 && b <= 8'hef) begin
            cont_left = 2'd2;
            if (b == 8'he0) begin
               cont_rule = RULE_A0_BF;
            end else if (b == 8'hed) begin
               cont_rule = RULE_80_9F;
            end else begin
               cont_rule = RULE_ANY;
            end
         end else if (b >= 8'hf0 && b <= 8'hf4) begin
            cont_left = 2'd3;
            if (b == 8'hf0) begin
               cont_rule = RULE_90_BF;
            end else if (b == 8'hf4) begin
               cont_rule = RULE_80_8F;
            end else begin
               cont_rule = RULE_ANY;
            end
         end else begin
            bad_seen = 1'b1;
         end
      end
   endtask

   // Hold one character back so the last one of a request can get run_end.
   task automatic stage_char(input logic [7:0] c, input logic str_end, input logic str_ok);
      if (staged_ok) begin
         expected_chars.insert(expected_chars.size(), staged);
      end
      staged    = {c, 1'b0, str_end, str_ok};
      staged_ok = 1'b1;
   endtask

   task automatic escape_byte(input logic [7:0] b);
      logic       has_short;
      logic [7:0] short_code;
      has_short  = 1'b1;
      short_code = b;
      unique case (b)
         jse_pkg::CHAR_QUOTE, jse_pkg::CHAR_BSLASH: short_code = b;
         CHAR_BACKSPACE:          short_code = "b";
         CHAR_FORMFEED:           short_code = "f";
         CHAR_NEWLINE:            short_code = "n";
         CHAR_RETURN:             short_code = "r";
         CHAR_TAB:                short_code = "t";
         default:                 has_short = 1'b0;
      endcase
      if (has_short) begin
         stage_char(jse_pkg::CHAR_BSLASH, 1'b0, 1'b0);
         stage_char(short_code, 1'b0, 1'b0);
      end else if (b < CHAR_SPACE) begin
         stage_char(jse_pkg::CHAR_BSLASH, 1'b0, 1'b0);
         stage_char(jse_pkg::CHAR_U, 1'b0, 1'b0);
         stage_char(jse_pkg::CHAR_ZERO, 1'b0, 1'b0);
         stage_char(jse_pkg::CHAR_ZERO, 1'b0, 1'b0);
         stage_char(hex_digits.getc(int'(b[7:4])), 1'b0, 1'b0);
         stage_char(hex_digits.getc(int'(b[3:0])), 1'b0, 1'b0);
      end else begin
         stage_char(b, 1'b0, 1'b0);
      end
   endtask

   task automatic predict_escaped_chars(input logic [7:0] b, input logic first,
                                        input logic last, input logic empty);
      staged_ok = 1'b0;
      if (empty) begin
         stage_char(jse_pkg::CHAR_QUOTE, 1'b0, 1'b0);
         stage_char(jse_pkg::CHAR_QUOTE, 1'b1, 1'b1);
         clear_utf8();
      end else begin
         if (first) begin
            clear_utf8();
            stage_char(jse_pkg::CHAR_QUOTE, 1'b0, 1'b0);
         end
         advance_utf8(b);
         escape_byte(b);
         if (last) begin
            // an unfinished sequence at the end is truncated
            if (cont_left != 2'd0) begin
               bad_seen = 1'b1;
            end
            stage_char(jse_pkg::CHAR_QUOTE, 1'b1, !bad_seen);
            clear_utf8();
         end
      end
      staged.run_end = 1'b1;
      expected_chars.insert(expected_chars.size(), staged);
   endtask

   task automatic check_char();
      json_char_type got;
      json_char_type want;
      got = {rsp_out_char, rsp_run_end, rsp_string_end, rsp_string_valid};
      if (expected_chars.size() == 0) begin
         $display("%0t: unexpected response char %h run_end %b string_end %b string_valid %b",
                  $time, got.ch, got.run_end, got.str_end, got.str_ok);
         mismatch_count++;
      end else begin
         want = expected_chars.pop_front();
         chars_checked++;
         if (got.ch !== want.ch || got.run_end !== want.run_end ||
             got.str_end !== want.str_end || got.str_ok !== want.str_ok) begin
            $display("%0t: expected char %h run_end %b string_end %b string_valid %b",
                     $time, want.ch, want.run_end, want.str_end, want.str_ok);
            $display("%0t:      got char %h run_end %b string_end %b string_valid %b",
                     $time, got.ch, got.run_end, got.str_end, got.str_ok);
            mismatch_count++;
         end
         if (want.str_end) begin
            if (want.str_ok) begin
               strings_good++;
            end else begin
               strings_bad++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_utf8();
         expected_chars.delete();
         staged_ok = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_char();
         end
         if (req_valid && req_ready) begin
            predict_escaped_chars(req_data_byte, req_first_byte, req_last_byte,
                                  req_empty_string);
         end
      end
      chars_pending = expected_chars.size();
   end

endmodule

@@ bench/json_string_escape_utf8_check_top_tb.sv @@
// Testbench top for the JSON string escaper: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module json_string_escape_utf8_check_top_tb;

   localparam int STALL_LIMIT      = 2000;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int PHASE_ITEMS      = 16;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte    = 8'h00;
   logic       req_first_byte   = 1'b0;
   logic       req_last_byte    = 1'b0;
   logic       req_empty_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready        = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_run_end;
   logic       rsp_string_end;
   logic       rsp_string_valid;

   int mismatch_count;
   int chars_pending;
   int chars_checked;
   int strings_good;
   int strings_bad;

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic hold_rsp_long  = 1'b0;
   int   requests_sent  = 0;
   int   strings_sent   = 0;
   int   quiet_cycles   = 0;
   logic [7:0] text_bytes[$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   json_string_escape_utf8_check_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_first_byte   (req_first_byte),
      .req_last_byte    (req_last_byte),
      .req_empty_string (req_empty_string),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_run_end      (rsp_run_end),
      .rsp_string_end   (rsp_string_end),
      .rsp_string_valid (rsp_string_valid)
   );

   jse_stream_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_first_byte   (req_first_byte),
      .req_last_byte    (req_last_byte),
      .req_empty_string (req_empty_string),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_run_end      (rsp_run_end),
      .rsp_string_end   (rsp_string_end),
      .rsp_string_valid (rsp_string_valid),
      .mismatch_count   (mismatch_count),
      .chars_pending    (chars_pending),
      .chars_checked    (chars_checked),
      .strings_good     (strings_good),
      .strings_bad      (strings_bad)
   );

   // Receiver: random stalls, or one long hold-off when asked.
   always @(negedge clock) begin
      if (hold_rsp_long) begin
         rsp_ready <= 1'b0;
         repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
         hold_rsp_long = 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no request or response accepted for %0d cycles", $time, STALL_LIMIT);
         $display("[json_string_escape_utf8_check_top] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input logic [7:0] b, input logic first, input logic last,
                               input logic empty);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= b;
      req_first_byte   <= first;
      req_last_byte    <= last;
      req_empty_string <= empty;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic send_string(input logic with_first, input logic with_last);
      int n;
      n = text_bytes.size();
      strings_sent++;
      if (n == 0) begin
         send_request(8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'b1);
      end else begin
         for (int i = 0; i < n; i++) begin
            send_request(text_bytes[i], with_first && (i == 0), with_last && (i == n - 1),
                         1'b0);
         end
      end
   endtask

   // Append one byte to the text under construction.
   task automatic add_byte(input logic [7:0] v);
      text_bytes.insert(text_bytes.size(), v);
   endtask

   task automatic push_utf8_char();
      int         kind;
      logic [7:0] lead;
      kind = $urandom_range(9);
      if (kind < 4) begin
         add_byte(8'($urandom_range(127)));
      end else if (kind < 6) begin
         add_byte(8'($urandom_range(8'hdf, 8'hc2)));
         add_byte(8'($urandom_range(8'hbf, 8'h80)));
      end else if (kind < 8) begin
         // lean on the leads with narrowed second-byte ranges
         if ($urandom_range(1)) begin
            lead = $urandom_range(1) ? 8'he0 : 8'hed;
         end else begin
            lead = 8'($urandom_range(8'hef, 8'he0));
         end
         add_byte(lead);
         if (lead == 8'he0) begin
            add_byte(8'($urandom_range(8'hbf, 8'ha0)));
         end else if (lead == 8'hed) begin
            add_byte(8'($urandom_range(8'h9f, 8'h80)));
         end else begin
            add_byte(8'($urandom_range(8'hbf, 8'h80)));
         end
         add_byte(8'($urandom_range(8'hbf, 8'h80)));
      end else begin
         if ($urandom_range(1)) begin
            lead = $urandom_range(1) ? 8'hf0 : 8'hf4;
         end else begin
            lead = 8'($urandom_range(8'hf4, 8'hf0));
         end
         add_byte(lead);
         if (lead == 8'hf0) begin
            add_byte(8'($urandom_range(8'hbf, 8'h90)));
         end else if (lead == 8'hf4) begin
            add_byte(8'($urandom_range(8'h8f, 8'h80)));
         end else begin
            add_byte(8'($urandom_range(8'hbf, 8'h80)));
         end
         add_byte(8'($urandom_range(8'hbf, 8'h80)));
         add_byte(8'($urandom_range(8'hbf, 8'h80)));
      end
   endtask

   // Mostly well-formed text; a quarter gets corrupted or truncated.
   task automatic make_text(input int max_chars);
      int n;
      int pos;
      text_bytes.delete();
      n = $urandom_range(max_chars);
      repeat (n) push_utf8_char();
      if ($urandom_range(99) < 25) begin
         case ($urandom_range(2))
            0: begin
               if (text_bytes.size() > 0) begin
                  pos = $urandom_range(text_bytes.size() - 1);
                  text_bytes[pos] = 8'($urandom_range(255));
               end
            end
            1: begin
               if (text_bytes.size() > 0) begin
                  void'(text_bytes.pop_back());
               end
            end
            default: add_byte(8'($urandom_range(8'hff, 8'h80)));
         endcase
      end
   endtask

   task automatic run_random(input int item_goal);
      int start;
      start = requests_sent;
      while (requests_sent - start < item_goal) begin
         make_text(6);
         send_string($urandom_range(99) >= 8, $urandom_range(99) >= 8);
      end
   endtask

   // Drop valid and wait out every expected character.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (chars_pending != 0);
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, no idling
      send_request(8'hff, 1'b1, 1'b1, 1'b1);
      send_request(8'h00, 1'b1, 1'b1, 1'b0);
      text_bytes = '{8'h22, 8'h5c, 8'h08, 8'h0c, 8'h0a, 8'h0d, 8'h09, 8'h1f, 8'h7f, 8'h20};
      send_string(1'b1, 1'b1);
      text_bytes = '{8'he0, 8'ha0, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
      send_string(1'b1, 1'b1);
      // surrogate, then a sequence cut off by the end of the string
      text_bytes = '{8'hed, 8'ha0, 8'hf0};
      send_string(1'b1, 1'b1);
      // bytes outside any string, starting with an overlong lead
      text_bytes = '{8'hc0, 8'h41};
      send_string(1'b0, 1'b1);
      // a string left open, then a restart that clears the checker
      send_request(8'hc2, 1'b1, 1'b0, 1'b0);
      send_request(8'h41, 1'b1, 1'b1, 1'b0);
      run_random(PHASE_ITEMS);
      drain();

      send_idle_pct  = 70;
      recv_stall_pct = 0;
      run_random(PHASE_ITEMS);
      drain();

      // long receiver hold-off while control bytes keep coming
      send_idle_pct  = 0;
      recv_stall_pct = 70;
      hold_rsp_long  = 1'b1;
      text_bytes.delete();
      repeat (10) add_byte(8'($urandom_range(31)));
      send_string(1'b1, 1'b1);
      run_random(PHASE_ITEMS);
      drain();

      send_idle_pct  = 28;
      recv_stall_pct = 28;
      run_random(PHASE_ITEMS);
      drain();

      repeat (20) @(negedge clock);
      $display("Sent %0d requests in %0d strings across four traffic phases; %0d chars checked.",
               requests_sent, strings_sent, chars_checked);
      $display("Closing quotes: %0d well-formed, %0d rejected; mismatches: %0d.",
               strings_good, strings_bad, mismatch_count);
      if (mismatch_count == 0 && chars_pending == 0) begin
         $display("[json_string_escape_utf8_check_top] OK");
      end else begin
         $display("[json_string_escape_utf8_check_top] ERROR");
      end
      $finish;
   end

endmodule
